/* src/distinct_window_marker_detector_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the distinct window marker detector
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_WINDOW_MARKER_DETECTOR_UNIT_ASSERT_SVH
`define DISTINCT_WINDOW_MARKER_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DWMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dwmd_pkg.sv */
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared types and constants of the distinct window marker detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dwmd_pkg;

  localparam int unsigned SYM_BITS   = 8;
  localparam int unsigned SYM_COUNT  = 256;
  localparam int unsigned WLEN_BITS  = 4;
  localparam logic [3:0]  WLEN_RESET = 4'd4;
  localparam int unsigned POS_BITS   = 24;
  localparam logic [23:0] POS_MAX    = 24'hFF_FFFF;
  // stamp modulus 64 exceeds twice the largest supported window
  localparam int unsigned STAMP_BITS = 6;

  typedef logic [SYM_BITS-1:0]   sym_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // last-seen table read result
  typedef struct packed {
    logic   hit;
    stamp_t stamp;
  } hist_rd_t;

  // last-seen table write request
  typedef struct packed {
    logic   en;
    sym_t   sym;
    stamp_t stamp;
  } hist_wr_t;

  // one result transaction
  typedef struct packed {
    logic                marker;
    logic [POS_BITS-1:0] pos;
    logic                already;
  } res_t;

endpackage

`default_nettype wire

/* src/distinct_window_marker_detector_unit.sv */
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_unit
// Flags the first byte at which the trailing window_len bytes all differ.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  input     valid_i / stall_o   symbol_i, restart_i
//  output    valid_o / stall_i   marker_found_o, position_o, already_found_o
//  config    cfg_we_i            cfg_wdata_i (window_len)
//
//  One transaction per cycle sustained while the output is not stalled; an input
//  is registered with its table read, then its check into the output register.
//  The rate is set by the last-seen table, read once and written once per cycle.
//  Reset clears the stream state and sets window_len to 4; no clearing pass.
//  Stalls back up one stage at a time: input is taken while a result waits
//  as long as the check stage is free.
//
`default_nettype none

module distinct_window_marker_detector_unit #(
  parameter int unsigned WINDOW_MAX = 14,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [dwmd_pkg::WLEN_BITS-1:0]      cfg_wdata_i,
  input  wire                                 valid_i,
  output logic                                stall_o,
  input  wire  [dwmd_pkg::SYM_BITS-1:0]       symbol_i,
  input  wire                                 restart_i,
  output logic                                valid_o,
  input  wire                                 stall_i,
  output logic                                marker_found_o,
  output logic [dwmd_pkg::POS_BITS-1:0]       position_o,
  output logic                                already_found_o
);

`include "distinct_window_marker_detector_unit_assert.svh"

  // window length register
  logic [dwmd_pkg::WLEN_BITS-1:0] wlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= dwmd_pkg::WLEN_RESET;
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

  // handshake and stage control
  logic out_ready, s1_adv, s1_free, in_acc;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  dwmd_pkg::sym_t   s1_sym_q;
  logic             s1_restart_q;
  dwmd_pkg::stamp_t s1_stamp_q;
  dwmd_pkg::stamp_t stamp_q;

  dwmd_pkg::hist_rd_t hist_rd;
  dwmd_pkg::hist_wr_t hist_wr;
  dwmd_pkg::res_t     res, out_q;

  always_comb begin
    out_ready   = !out_valid_q || !stall_i;
    s1_adv      = s1_valid_q && out_ready;
    s1_free     = !s1_valid_q || out_ready;
    in_acc      = valid_i && s1_free;
    stall_o     = !s1_free;
    s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stamp_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // advance the occurrence stamp once per transaction
      if (in_acc) begin
        stamp_q <= stamp_q + dwmd_pkg::stamp_t'(1);
      end
    end
  end

  // hold the check stage payload until it moves on
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sym_q     <= symbol_i;
      s1_restart_q <= restart_i;
      s1_stamp_q   <= stamp_q;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // look up where this byte was last seen
  dwmd_hist_mem u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .rd_sym_i (symbol_i),
    .wr_i     (hist_wr),
    .rd_o     (hist_rd)
  );

  // update the distinct run and decide the marker
  dwmd_scan #(
    .WINDOW_MAX (WINDOW_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .sym_i     (s1_sym_q),
    .restart_i (s1_restart_q),
    .stamp_i   (s1_stamp_q),
    .wlen_i    (wlen_q),
    .rd_i      (hist_rd),
    .wr_o      (hist_wr),
    .res_o     (res)
  );

  assign valid_o         = out_valid_q;
  assign marker_found_o  = out_q.marker;
  assign position_o      = out_q.pos;
  assign already_found_o = out_q.already;

  // a marker is never reported on a stream that already had one
  `DWMD_ASSERT_NOW(a_marker_once, valid_o && marker_found_o, !already_found_o, "marker repeated")
  // every result counts at least its own byte
  `DWMD_ASSERT_NOW(a_pos_nonzero, valid_o, position_o != '0, "position zero")
  // a blocked check stage keeps its transaction
  `DWMD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv,
                    s1_valid_q && $stable(s1_sym_q) && $stable(s1_stamp_q), "check stage lost")

endmodule

`default_nettype wire

/* src/dwmd_hist_mem.sv */
// ----------------------------------------------------------------------------
// dwmd_hist_mem
// Last-seen table: per byte value, the stamp of its latest occurrence.
// One read and one write per cycle, registered read with write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmd_hist_mem (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               rd_en_i,
  input  dwmd_pkg::sym_t    rd_sym_i,
  input  dwmd_pkg::hist_wr_t wr_i,
  output dwmd_pkg::hist_rd_t rd_o
);

  dwmd_pkg::stamp_t            mem_q [dwmd_pkg::SYM_COUNT];
  logic [dwmd_pkg::SYM_COUNT-1:0] written_q;
  dwmd_pkg::hist_rd_t          rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.sym] <= wr_i.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.en) begin
      written_q[wr_i.sym] <= 1'b1;
    end
  end

  // forward a write to the same entry in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.sym == rd_sym_i)) begin
        rd_q.hit   <= 1'b1;
        rd_q.stamp <= wr_i.stamp;
      end else begin
        rd_q.hit   <= written_q[rd_sym_i];
        rd_q.stamp <= mem_q[rd_sym_i];
      end
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

/* src/dwmd_scan.sv */
// ----------------------------------------------------------------------------
// dwmd_scan
// Stream state and window check: tracks the longest all-distinct suffix
// from the distance to each byte's previous occurrence.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmd_scan #(
  parameter int unsigned WINDOW_MAX = 14,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              adv_i,
  input  dwmd_pkg::sym_t                   sym_i,
  input  wire                              restart_i,
  input  dwmd_pkg::stamp_t                 stamp_i,
  input  wire  [dwmd_pkg::WLEN_BITS-1:0]   wlen_i,
  input  dwmd_pkg::hist_rd_t               rd_i,
  output dwmd_pkg::hist_wr_t               wr_o,
  output dwmd_pkg::res_t                   res_o
);

  localparam int unsigned FW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IW = $clog2(WINDOW_MAX);
  localparam int unsigned CW = (COUNT_BITS > dwmd_pkg::POS_BITS) ? COUNT_BITS
                                                                 : dwmd_pkg::POS_BITS;

  dwmd_pkg::sym_t         recent_q [WINDOW_MAX];
  logic [FW-1:0]          fill_q, fill_d, fill_eff;
  logic [FW-1:0]          run_q, run_d, run_eff;
  logic [COUNT_BITS-1:0]  count_q, count_d, count_eff;
  logic                   found_q, found_d, found_eff;

  dwmd_pkg::stamp_t gap;
  logic [IW-1:0]    idx;
  logic             prev_ok;
  logic [FW:0]      run_inc, run_cap;
  logic [FW-1:0]    n_eff;
  logic             marker;
  logic [CW-1:0]    cnt_w;

  always_comb begin
    // restart drops the stream state before this byte is taken
    fill_eff  = restart_i ? '0 : fill_q;
    run_eff   = restart_i ? '0 : run_q;
    count_eff = restart_i ? '0 : count_q;
    found_eff = restart_i ? 1'b0 : found_q;

    gap = stamp_i - rd_i.stamp;
    idx = IW'(gap - dwmd_pkg::stamp_t'(1));
    // a stale stamp may alias, so confirm against the history itself
    prev_ok = rd_i.hit && (gap != '0) && (gap <= dwmd_pkg::stamp_t'(fill_eff)) &&
              (recent_q[idx] == sym_i);

    run_inc = {1'b0, run_eff} + (FW+1)'(1);
    run_cap = prev_ok ? (FW+1)'(gap) : (FW+1)'(WINDOW_MAX);
    run_d   = (run_inc < run_cap) ? run_inc[FW-1:0] : run_cap[FW-1:0];

    fill_d  = (fill_eff < FW'(WINDOW_MAX)) ? fill_eff + FW'(1) : fill_eff;
    count_d = (count_eff == '1) ? count_eff : count_eff + COUNT_BITS'(1);

    if (wlen_i == '0) begin
      n_eff = FW'(1);
    end else if (int'(wlen_i) > WINDOW_MAX) begin
      n_eff = FW'(WINDOW_MAX);
    end else begin
      n_eff = FW'(wlen_i);
    end

    marker  = !found_eff && (run_d >= n_eff);
    found_d = found_eff || marker;

    cnt_w = CW'(count_d);
    res_o.marker  = marker;
    res_o.already = found_eff;
    res_o.pos     = (cnt_w > CW'(dwmd_pkg::POS_MAX)) ? dwmd_pkg::POS_MAX
                                                     : cnt_w[dwmd_pkg::POS_BITS-1:0];

    wr_o.en    = adv_i;
    wr_o.sym   = sym_i;
    wr_o.stamp = stamp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      run_q   <= '0;
      count_q <= '0;
      found_q <= 1'b0;
    end else if (adv_i) begin
      fill_q  <= fill_d;
      run_q   <= run_d;
      count_q <= count_d;
      found_q <= found_d;
    end
  end

  // newest byte at entry 0
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      recent_q[0] <= sym_i;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        recent_q[i] <= recent_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the distinct window marker detector. A short
// directed table covers reset behavior, both window length extremes and the
// fill gating. Random streams then follow under several window_len settings,
// with idle gaps on both channels and a long back-pressure hold. Every result
// transaction is checked against its table entry or an in-bench window scanner.
// ----------------------------------------------------------------------------
module tb_top;
  import dwmd_pkg::*;

  localparam int unsigned WIN_DEPTH   = 14;
  localparam int unsigned RAND_ITEMS  = 700;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned WDOG_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 4;
  localparam int unsigned DIR_ROWS    = 28;
  localparam int unsigned DIR_ITEMS   = 26;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table: either a byte or a window_len write.
  // When typed is set, want holds the result read straight off the spec.
  typedef struct packed {
    row_kind_e             kind;
    sym_t                  sym;
    logic                  restart;
    logic [WLEN_BITS-1:0]  wlen;
    logic                  typed;
    res_t                  want;
  } dir_row_t;

  // DUT ports
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [WLEN_BITS-1:0] cfg_wdata_i;
  logic                 valid_i;
  logic                 stall_o;
  sym_t                 symbol_i;
  logic                 restart_i;
  logic                 valid_o;
  logic                 stall_i;
  logic                 marker_found_o;
  logic [POS_BITS-1:0]  position_o;
  logic                 already_found_o;

  // Scanner state: a private copy of the window history and counters
  sym_t                 win_hist [WIN_DEPTH];
  int unsigned          win_fill;
  logic [POS_BITS-1:0]  win_count;
  logic                 win_found;
  logic [WLEN_BITS-1:0] win_len_cfg;

  // Verdicts waiting for their result transaction, oldest first
  res_t                 window_verdicts_q [$];

  dir_row_t             dir_table [DIR_ROWS];

  // Channel control shared between the main sequence and the receiver
  logic                 tx_idle_en;
  logic                 rx_idle_en;
  logic                 hold_req;
  int unsigned          hold_left;

  int unsigned          err_cnt;
  int unsigned          items_sent;
  int unsigned          results_checked;
  int unsigned          markers_seen;
  int unsigned          cfg_writes;
  int unsigned          idle_cycles;

  distinct_window_marker_detector_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .symbol_i        (symbol_i),
    .restart_i       (restart_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .marker_found_o  (marker_found_o),
    .position_o      (position_o),
    .already_found_o (already_found_o)
  );

  // 12 ns period
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scanner: shift the byte in, then look for the first all-distinct window
  // --------------------------------------------------------------------------
  function automatic int unsigned eff_window(input logic [WLEN_BITS-1:0] len);
    // zero behaves as one, anything past the history depth is clamped
    if (len == '0) return 1;
    if (len > WIN_DEPTH) return WIN_DEPTH;
    return len;
  endfunction

  function automatic res_t scan_window(input sym_t sym, input logic restart);
    res_t        r;
    int unsigned n;
    logic        distinct;
    if (restart) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_hist[i] = '0;
      win_fill  = 0;
      win_count = '0;
      win_found = 1'b0;
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
    win_hist[0] = sym;
    if (win_fill < WIN_DEPTH) win_fill++;
    // saturate the byte counter at all ones
    if (win_count != '1) win_count++;
    n = eff_window(win_len_cfg);
    distinct = 1'b1;
    for (int a = 0; a < n; a++) begin
      for (int b = a + 1; b < n; b++) begin
        if (win_hist[a] == win_hist[b]) distinct = 1'b0;
      end
    end
    r.already = win_found;
    r.marker  = !win_found && (win_fill >= n) && distinct;
    if (r.marker) win_found = 1'b1;
    // counter and position share a width, so the count is the position
    r.pos = win_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table rows
  // --------------------------------------------------------------------------
  function automatic dir_row_t item_row(input sym_t sym, input logic rs, input logic mk,
                                        input int unsigned pos, input logic al);
    dir_row_t row;
    row.kind         = ROW_ITEM;
    row.sym          = sym;
    row.restart      = rs;
    row.wlen         = '0;
    row.typed        = 1'b1;
    row.want.marker  = mk;
    row.want.pos     = pos[POS_BITS-1:0];
    row.want.already = al;
    return row;
  endfunction

  function automatic dir_row_t scan_row(input sym_t sym, input logic rs);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.sym     = sym;
    row.restart = rs;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [WLEN_BITS-1:0] len);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.wlen = len;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: print one line and count
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Input side. Each task starts at a falling edge and returns at the rising
  // edge where its last action took effect.
  // --------------------------------------------------------------------------

  // Offer one byte; hold the payload until the DUT takes it, then predict.
  task automatic send_item(input sym_t sym, input logic restart, input logic typed,
                           input res_t want);
    res_t r;
    @(negedge clk_i);
    // idle gaps: drop valid for a random number of cycles
    while (tx_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i   <= 1'b1;
    symbol_i  <= sym;
    restart_i <= restart;
    do @(posedge clk_i); while (stall_o);
    // transaction accepted at this edge
    r = scan_window(sym, restart);
    window_verdicts_q.push_back(typed ? want : r);
    items_sent++;
  endtask

  // Stop offering and wait for every pending result, plus the pipeline tail.
  task automatic drain_results();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (window_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write window_len; only called with nothing in flight.
  task automatic write_window_len(input logic [WLEN_BITS-1:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    win_len_cfg = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // One stream of random bytes. A narrow alphabet near the window length
  // produces lots of near misses so the marker lands late or never; the full
  // alphabet exercises every symbol bit. Sprinkle stray restarts as noise.
  // Stop early once the item budget is spent.
  task automatic run_stream(input int unsigned len, input logic open_with_restart);
    logic        narrow;
    sym_t        base;
    int unsigned span;
    int unsigned eff;
    sym_t        s;
    logic        rs;
    narrow = ($urandom_range(99) < 60);
    base   = sym_t'($urandom_range(255));
    eff    = eff_window(win_len_cfg);
    span   = ((eff > 1) ? eff - 1 : 1) + $urandom_range(4);
    for (int k = 0; k < len; k++) begin
      if (items_sent >= DIR_ITEMS + RAND_ITEMS) break;
      s  = narrow ? sym_t'(base + $urandom_range(span - 1)) : sym_t'($urandom_range(255));
      rs = (k == 0) ? open_with_restart : ($urandom_range(99) < 3);
      send_item(s, rs, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall at random, or for a long counted hold when asked
  // --------------------------------------------------------------------------
  initial begin
    stall_i   = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else if (rx_idle_en) begin
        stall_i <= ($urandom_range(99) < IDLE_PCT);
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each result transaction with the oldest verdict
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (window_verdicts_q.size() == 0) begin
        report_mismatch("result with nothing pending", position_o, 0);
      end else begin
        want = window_verdicts_q.pop_front();
        results_checked++;
        if (marker_found_o === 1'b1) markers_seen++;
        if (marker_found_o !== want.marker)
          report_mismatch("marker_found", marker_found_o, want.marker);
        if (position_o !== want.pos)
          report_mismatch("position", position_o, want.pos);
        if (already_found_o !== want.already)
          report_mismatch("already_found", already_found_o, want.already);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, WDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned          phase;
    logic [WLEN_BITS-1:0] len;

    // drive every input to a known value from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    valid_i         = 1'b0;
    symbol_i        = '0;
    restart_i       = 1'b0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    hold_req        = 1'b0;
    err_cnt         = 0;
    items_sent      = 0;
    results_checked = 0;
    markers_seen    = 0;
    cfg_writes      = 0;
    idle_cycles     = 0;

    // scanner starts from the reset state
    for (int i = 0; i < WIN_DEPTH; i++) win_hist[i] = '0;
    win_fill    = 0;
    win_count   = '0;
    win_found   = 1'b0;
    win_len_cfg = WLEN_RESET;

    dir_table = '{
      // reset window length of four: duplicates hold off the marker
      item_row(8'h00, 1'b0, 1'b0, 1, 1'b0),
      item_row(8'h00, 1'b0, 1'b0, 2, 1'b0),
      item_row(8'hFF, 1'b0, 1'b0, 3, 1'b0),
      item_row(8'h01, 1'b0, 1'b0, 4, 1'b0),
      item_row(8'h80, 1'b0, 1'b1, 5, 1'b0),
      item_row(8'h80, 1'b0, 1'b0, 6, 1'b1),
      // restart; marker exactly when the history first covers the window
      item_row(8'h10, 1'b1, 1'b0, 1, 1'b0),
      scan_row(8'h20, 1'b0),
      scan_row(8'h30, 1'b0),
      item_row(8'h40, 1'b0, 1'b1, 4, 1'b0),
      // zero length acts as one: first byte is the marker
      cfg_row(4'd0),
      item_row(8'hAA, 1'b1, 1'b1, 1, 1'b0),
      item_row(8'hAA, 1'b0, 1'b0, 2, 1'b1),
      // length above the history depth clamps to fourteen
      cfg_row(4'd15),
      scan_row(8'h00, 1'b1),
      scan_row(8'h11, 1'b0),
      scan_row(8'h22, 1'b0),
      scan_row(8'h33, 1'b0),
      scan_row(8'h44, 1'b0),
      scan_row(8'h55, 1'b0),
      scan_row(8'h66, 1'b0),
      scan_row(8'h77, 1'b0),
      scan_row(8'h88, 1'b0),
      scan_row(8'h99, 1'b0),
      scan_row(8'hAA, 1'b0),
      scan_row(8'hBB, 1'b0),
      scan_row(8'hCC, 1'b0),
      item_row(8'hFF, 1'b0, 1'b1, 14, 1'b0)
    };

    // hold reset, release at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table; drain before each register write
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain_results();
        write_window_len(dir_table[i].wlen);
      end else begin
        send_item(dir_table[i].sym, dir_table[i].restart, dir_table[i].typed,
                  dir_table[i].want);
      end
    end

    // Random phases. Each phase drains (the sender pauses until every result
    // is back), picks a window length, then runs a few streams. The first
    // stream of a phase sometimes skips the restart, so a length change lands
    // in the middle of a stream.
    phase = 0;
    while (items_sent < DIR_ITEMS + RAND_ITEMS) begin
      drain_results();
      case (phase)
        0:       len = 4'd1;
        1:       len = 4'd14;
        2:       len = 4'd15;
        3:       len = 4'd0;
        default: len = $urandom_range(15);
      endcase
      write_window_len(len);
      // phase one: long receiver hold with the sender pushing back to back
      // phase two: no idling on either side
      tx_idle_en = (phase > 2);
      rx_idle_en = (phase != 2);
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(6, 2)) begin
        run_stream($urandom_range(40, (phase == 1) ? 24 : 3), $urandom_range(3) != 0);
      end
      phase++;
    end

    drain_results();
    if (window_verdicts_q.size() != 0)
      report_mismatch("results never delivered", window_verdicts_q.size(), 0);

    $display("Covered %0d bytes over %0d window_len writes and %0d random phases.",
             items_sent, cfg_writes, phase);
    $display("Checked %0d results, %0d of them markers; %0d mismatches.",
             results_checked, markers_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* distinct_window_marker_detector_unit.f */
+incdir+src
src/dwmd_pkg.sv
src/dwmd_hist_mem.sv
src/dwmd_scan.sv
src/distinct_window_marker_detector_unit.sv
test/tb_top.sv
